FILE: hdl/mqbfp_pkg.sv
// package with shared constants and types for the byte fifo pool
`default_nettype none
package mqbfp_pkg;
  localparam int NumQueuesDef = 64;
  localparam int QueueDepthDef = 256;
  localparam int MaxPopDef = 64;

  localparam int OpW = 3;
  localparam int QidW = 6;
  localparam int ByteW = 8;
  localparam int LenW = 8;
  localparam int StatW = 3;
  localparam int CntW = 7;

  localparam logic [OpW-1:0] OP_ALLOC = 3'd0;
  localparam logic [OpW-1:0] OP_FREE = 3'd1;
  localparam logic [OpW-1:0] OP_PUSH_BEGIN = 3'd2;
  localparam logic [OpW-1:0] OP_PUSH_BYTE = 3'd3;
  localparam logic [OpW-1:0] OP_POP = 3'd4;

  localparam logic [StatW-1:0] ST_OK = 3'd0;
  localparam logic [StatW-1:0] ST_NOT_ALLOC = 3'd1;
  localparam logic [StatW-1:0] ST_TOO_LONG = 3'd2;
  localparam logic [StatW-1:0] ST_FULL = 3'd3;
  localparam logic [StatW-1:0] ST_NOT_EMPTY = 3'd4;
  localparam logic [StatW-1:0] ST_EXHAUSTED = 3'd5;

  // one result item
  typedef struct packed {
    logic [StatW-1:0] status;
    logic [QidW-1:0]  result_queue;
    logic [ByteW-1:0] out_byte;
    logic             byte_valid;
    logic [CntW-1:0]  popped_count;
    logic             last;
  } res_t;
endpackage
`default_nettype wire

FILE: hdl/multi_queue_byte_fifo_pool.sv
// top level of the multi-queue byte fifo pool
// usage:
//  - s_axis carries commands: alloc, free, push_begin, push_byte, pop
//  - m_axis carries result transfers; each command gives one result,
//    pop gives one result per popped byte (up to MAX_POP), tlast marks the
//    final result of a command; opcodes 5..7 give nothing
//  - all pointers, fill levels and the bytes sit in two synchronous rams
//    (queue descriptor ram and byte ram), both with a registered read
//  - a command passes accept (descriptor read issued), then the update in
//    the exec state; a pop then runs each popped byte through a byte ram
//    read and then a load of the output register
//  - one command in flight at a time; s_axis_tready is low while busy
//  - results go through a one-entry output register; a stalled receiver
//    holds the machine until the register drains
//  - after reset all queues are free and no block is open; the descriptor
//    ram is not cleared since alloc writes the descriptor before use
//  - the allocation bitmap lives in flip-flops, lowest free id found by a
//    priority scan
`default_nettype none
module multi_queue_byte_fifo_pool
  import mqbfp_pkg::*;
#(
  parameter int NUM_QUEUES = NumQueuesDef,
  parameter int QUEUE_DEPTH = QueueDepthDef,
  parameter int MAX_POP = MaxPopDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // opcode[2:0], queue_id[8:3], data[16:9], request_len[24:17], zeros
  input  wire logic [31:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // status[2:0], result_queue[8:3], out_byte[16:9], byte_valid[17],
  // popped_count[24:18], zeros
  output logic [31:0]      m_axis_tdata_o,
  output logic             m_axis_tlast_o
);
  localparam int QW = $clog2(NUM_QUEUES);
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int AW = QW + PW;
  localparam int DW = 3 * 9;   // head, tail, fill
  localparam logic [8:0] DepthM1 = 9'(QUEUE_DEPTH - 1);
  localparam logic [8:0] MaxPopC = 9'(MAX_POP);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POP = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0] state_q, state_d;
  logic [OpW-1:0] op_q;
  logic [QidW-1:0] qid_q;
  logic [ByteW-1:0] data_q;
  logic [LenW-1:0] len_q;
  logic [NUM_QUEUES-1:0] in_use_q, in_use_d;
  logic [LenW-1:0] ob_rem_q, ob_rem_d;
  logic [QidW-1:0] ob_q_q, ob_q_d;
  logic [QW-1:0] tq_q, tq_d;   // queue being worked on
  logic [8:0] head_q, head_d, fill_q, fill_d, tail_q, n_q, n_d, i_q, i_d;
  logic ovalid_q, ovalid_d;
  res_t ores_q, ores_d;
  logic pend_q, pend_d;   // byte read issued, result due

  logic desc_we, desc_re;
  logic [QW-1:0] desc_wa, desc_ra;
  logic [DW-1:0] desc_wd, desc_rd;
  logic byte_we, byte_re;
  logic [AW-1:0] byte_wa, byte_ra;
  logic [7:0] byte_rd;

  mqbfp_ram #(.Width(DW), .Depth(NUM_QUEUES)) u_desc (
    .clk_i, .we_i(desc_we), .waddr_i(desc_wa), .wdata_i(desc_wd),
    .re_i(desc_re), .raddr_i(desc_ra), .rdata_o(desc_rd)
  );
  mqbfp_ram #(.Width(8), .Depth(NUM_QUEUES * QUEUE_DEPTH)) u_bytes (
    .clk_i, .we_i(byte_we), .waddr_i(byte_wa), .wdata_i(data_q),
    .re_i(byte_re), .raddr_i(byte_ra), .rdata_o(byte_rd)
  );

  // lowest free queue
  logic found;
  logic [QW-1:0] free_id;
  always_comb begin
    found = 1'b0;
    free_id = '0;
    for (int k = NUM_QUEUES - 1; k >= 0; k--) begin
      if (!in_use_q[k]) begin
        found = 1'b1;
        free_id = QW'(k);
      end
    end
  end

  logic s_acc, out_free;
  assign s_axis_tready_o = (state_q == S_IDLE) && !ovalid_q;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !ovalid_q || m_axis_tready_i;

  logic qid_ok, cur_ok;
  assign qid_ok = ({2'b0, qid_q} < 8'(NUM_QUEUES)) && in_use_q[qid_q[QW-1:0]];

  logic [8:0] d_head, d_tail, d_fill, nxt_tail, nxt_head;
  assign {d_head, d_tail, d_fill} = desc_rd;
  assign nxt_tail = (d_tail + 9'd1) & DepthM1;
  assign nxt_head = (head_q + 9'd1) & DepthM1;
  assign cur_ok = ({2'b0, ob_q_q} < 8'(NUM_QUEUES)) && in_use_q[ob_q_q[QW-1:0]];

  always_comb begin
    state_d = state_q; in_use_d = in_use_q; ob_rem_d = ob_rem_q;
    ob_q_d = ob_q_q; tq_d = tq_q; head_d = head_q; fill_d = fill_q;
    n_d = n_q; i_d = i_q; pend_d = pend_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    ores_d = ores_q;
    desc_we = 1'b0; desc_wa = tq_q; desc_wd = '0;
    desc_re = 1'b0; desc_ra = s_axis_tdata_i[3+:QW];
    byte_we = 1'b0; byte_wa = '0; byte_re = 1'b0; byte_ra = {tq_q, nxt_head[PW-1:0]};
    unique case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          desc_re = 1'b1;
          if (s_axis_tdata_i[2:0] == OP_PUSH_BYTE) desc_ra = ob_q_q[QW-1:0];
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        ores_d = '0;
        ores_d.last = 1'b1;
        ovalid_d = 1'b1;
        state_d = S_IDLE;
        unique case (op_q)
          OP_ALLOC: begin
            if (!found) ores_d.status = ST_EXHAUSTED;
            else begin
              in_use_d[free_id] = 1'b1;
              desc_we = 1'b1; desc_wa = free_id; desc_wd = '0;
              ores_d.result_queue = QidW'(free_id);
            end
          end
          OP_FREE: begin
            if (!qid_ok) ores_d.status = ST_NOT_ALLOC;
            else if (d_fill != 9'd0) ores_d.status = ST_NOT_EMPTY;
            else begin
              in_use_d[qid_q[QW-1:0]] = 1'b0;
              if (ob_rem_q != '0 && ob_q_q == qid_q) ob_rem_d = '0;
            end
          end
          OP_PUSH_BEGIN: begin
            if (!qid_ok) ores_d.status = ST_NOT_ALLOC;
            else if ({1'b0, len_q} > DepthM1) ores_d.status = ST_TOO_LONG;
            else if ({1'b0, len_q} > DepthM1 - d_fill) ores_d.status = ST_FULL;
            else begin
              ob_rem_d = len_q; ob_q_d = qid_q;
            end
          end
          OP_PUSH_BYTE: begin
            if (ob_rem_q == '0 || !cur_ok) ores_d.status = ST_NOT_ALLOC;
            else begin
              desc_we = 1'b1; desc_wa = ob_q_q[QW-1:0];
              desc_wd = {d_head, nxt_tail, (d_fill + 9'd1) & 9'hff};
              byte_we = 1'b1; byte_wa = {ob_q_q[QW-1:0], nxt_tail[PW-1:0]};
              ob_rem_d = ob_rem_q - 8'd1;
            end
          end
          OP_POP: begin
            if (!qid_ok) ores_d.status = ST_NOT_ALLOC;
            else begin
              n_d = {1'b0, len_q};
              if (n_d > d_fill) n_d = d_fill;
              if (n_d > MaxPopC) n_d = MaxPopC;
              if (n_d != 9'd0) begin
                ovalid_d = 1'b0;
                head_d = d_head; fill_d = d_fill; i_d = '0;
                pend_d = 1'b0;
                state_d = S_POP;
              end
            end
          end
          default: begin
            ovalid_d = 1'b0;
          end
        endcase
      end
      S_POP: begin
        // issue one read; its data is shown next cycle
        if (out_free) begin
          byte_re = 1'b1;
          head_d = nxt_head;
          i_d = i_q + 9'd1;
          pend_d = 1'b1;
          state_d = S_OUT;
        end
      end
      default: begin
        // S_OUT: byte ram data valid, place it in the output register
        if (out_free) begin
          ores_d = '0;
          ores_d.out_byte = byte_rd;
          ores_d.byte_valid = 1'b1;
          ores_d.popped_count = n_q[CntW-1:0];
          ores_d.last = (i_q == n_q);
          ovalid_d = 1'b1;
          pend_d = 1'b0;
          if (i_q == n_q) begin
            desc_we = 1'b1;
            desc_wd = {head_q, tail_q, fill_q - n_q};
            state_d = S_IDLE;
          end else state_d = S_POP;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; in_use_q <= '0; ob_rem_q <= '0; ob_q_q <= '0;
      ovalid_q <= 1'b0; pend_q <= 1'b0;
    end else begin
      state_q <= state_d; in_use_q <= in_use_d; ob_rem_q <= ob_rem_d;
      ob_q_q <= ob_q_d; ovalid_q <= ovalid_d; pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      op_q <= s_axis_tdata_i[2:0];
      qid_q <= s_axis_tdata_i[8:3];
      data_q <= s_axis_tdata_i[16:9];
      len_q <= s_axis_tdata_i[24:17];
    end
    if (state_q == S_EXEC) begin
      tq_q <= qid_q[QW-1:0];
      tail_q <= d_tail;
    end else tq_q <= tq_d;
    head_q <= head_d; fill_q <= fill_d; n_q <= n_d; i_q <= i_d;
    ores_q <= ores_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tlast_o = ores_q.last;
  assign m_axis_tdata_o = {7'd0, ores_q.popped_count, ores_q.byte_valid,
                           ores_q.out_byte, ores_q.result_queue, ores_q.status};
endmodule
`default_nettype wire

FILE: hdl/mqbfp_ram.sv
// generic single-port-write, registered-read ram
`default_nettype none
module mqbfp_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: hdl/mqbfp_checker.sv
// port-level checker for the byte fifo pool, bound to the top level
`default_nettype none
module mqbfp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o,
  input wire logic        m_axis_tlast_o
);
  // result held while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed under stall");
  // no command taken while a result waits
  a_noacc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("command accepted with pending result");
  // one command at a time: ready drops after a transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("command accepted while busy");
  // byte results carry a nonzero count
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[17] |-> m_axis_tdata_o[24:18] != 7'd0)
    else $error("popped byte with zero count");
  // non-byte results are always last
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[17] |-> m_axis_tlast_o)
    else $error("status result not last");
endmodule

bind multi_queue_byte_fifo_pool mqbfp_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o, .m_axis_tvalid_o,
  .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tlast_o
);
`default_nettype wire

FILE: verif/testbench.sv
// testbench for the multi-queue byte fifo pool: directed and random commands with a predictor
`default_nettype none
module testbench
  import mqbfp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NQ = NumQueuesDef;
  localparam int DEPTH = QueueDepthDef;
  localparam int ROOM = QueueDepthDef - 1;
  localparam int RANDOM_ITEMS = 390;
  localparam int QUIET_ITEMS = 60;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;

  // predictor of the pool plus the store of expected results
  class pool_scoreboard;
    bit           granted[NQ];
    logic [7:0]   head[NQ];
    logic [7:0]   tail[NQ];
    logic [7:0]   level[NQ];
    logic [7:0]   bytes[NQ*DEPTH];
    int unsigned  blk_left;
    logic [5:0]   blk_q;
    res_t         pending_res[$];
    int           errors;

    function new();
      foreach (granted[i]) begin
        granted[i] = 0;
        head[i] = '0;
        tail[i] = '0;
        level[i] = '0;
      end
      blk_left = 0;
      blk_q = '0;
      errors = 0;
    endfunction

    function void add_res(logic [StatW-1:0] st, logic [5:0] rq, logic [7:0] b, logic bv,
                          logic [CntW-1:0] cnt, logic lst);
      res_t r;
      r.status = st;
      r.result_queue = rq;
      r.out_byte = b;
      r.byte_valid = bv;
      r.popped_count = cnt;
      r.last = lst;
      pending_res.push_back(r);
    endfunction

    // work out the results of one accepted command and update the state
    function void note_cmd(logic [2:0] op, logic [5:0] q, logic [7:0] d, logic [7:0] len);
      int unsigned n;
      int id;
      bit ok_q;
      ok_q = granted[q];
      case (op)
        OP_ALLOC: begin
          id = -1;
          for (int i = NQ - 1; i >= 0; i--) if (!granted[i]) id = i;
          if (id < 0) add_res(ST_EXHAUSTED, '0, '0, 1'b0, '0, 1'b1);
          else begin
            granted[id] = 1;
            head[id] = '0;
            tail[id] = '0;
            level[id] = '0;
            add_res(ST_OK, id[5:0], '0, 1'b0, '0, 1'b1);
          end
        end
        OP_FREE: begin
          if (!ok_q) add_res(ST_NOT_ALLOC, '0, '0, 1'b0, '0, 1'b1);
          else if (level[q] != 0) add_res(ST_NOT_EMPTY, '0, '0, 1'b0, '0, 1'b1);
          else begin
            granted[q] = 0;
            if (blk_left != 0 && blk_q == q) blk_left = 0;
            add_res(ST_OK, '0, '0, 1'b0, '0, 1'b1);
          end
        end
        OP_PUSH_BEGIN: begin
          if (!ok_q) add_res(ST_NOT_ALLOC, '0, '0, 1'b0, '0, 1'b1);
          else if (len > ROOM) add_res(ST_TOO_LONG, '0, '0, 1'b0, '0, 1'b1);
          else if (len > ROOM - level[q]) add_res(ST_FULL, '0, '0, 1'b0, '0, 1'b1);
          else begin
            blk_left = len;
            blk_q = q;
            add_res(ST_OK, '0, '0, 1'b0, '0, 1'b1);
          end
        end
        OP_PUSH_BYTE: begin
          if (blk_left == 0 || !granted[blk_q]) add_res(ST_NOT_ALLOC, '0, '0, 1'b0, '0, 1'b1);
          else begin
            // ring pointer wraps at the 8-bit boundary
            tail[blk_q] = tail[blk_q] + 8'd1;
            bytes[blk_q*DEPTH + tail[blk_q]] = d;
            level[blk_q] = level[blk_q] + 8'd1;
            blk_left--;
            add_res(ST_OK, '0, '0, 1'b0, '0, 1'b1);
          end
        end
        OP_POP: begin
          if (!ok_q) add_res(ST_NOT_ALLOC, '0, '0, 1'b0, '0, 1'b1);
          else begin
            n = len;
            if (n > level[q]) n = level[q];
            if (n > MaxPopDef) n = MaxPopDef;
            if (n == 0) add_res(ST_OK, '0, '0, 1'b0, '0, 1'b1);
            for (int i = 0; i < n; i++) begin
              head[q] = head[q] + 8'd1;
              add_res(ST_OK, '0, bytes[q*DEPTH + head[q]], 1'b1, n[CntW-1:0], i == n - 1);
            end
            level[q] = level[q] - n[7:0];
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_res.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer %h", got);
        return;
      end
      want = pending_res.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: expected st=%0d rq=%0d byte=%h bv=%b cnt=%0d last=%b,",
                    " got st=%0d rq=%0d byte=%h bv=%b cnt=%0d last=%b"},
                   want.status, want.result_queue, want.out_byte, want.byte_valid,
                   want.popped_count, want.last, got.status, got.result_queue,
                   got.out_byte, got.byte_valid, got.popped_count, got.last);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // opcode, queue_id, data, request_len, zeros (lowest bit up)
  logic [31:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // status, result_queue, out_byte, byte_valid, popped_count, zeros (lowest bit up)
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  pool_scoreboard pool_sb = new();
  bit  tx_gaps = 0;      // sender idling enabled
  bit  rx_gaps = 0;      // receiver idling enabled
  bit  hold_req = 0;     // ask the receiver for one long hold-off
  int  cycles = 0;
  int  items_sent = 0;

  multi_queue_byte_fifo_pool dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tlast_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** multi_queue_byte_fifo_pool: FAILED **");
      $finish;
    end
  end

  // receiver: checks every result transfer, stalls in short bursts and once for a long stretch
  int  stall_left = 0;
  bit  hold_done = 0;
  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.status = m_axis_tdata_o[2:0];
        got.result_queue = m_axis_tdata_o[8:3];
        got.out_byte = m_axis_tdata_o[16:9];
        got.byte_valid = m_axis_tdata_o[17];
        got.popped_count = m_axis_tdata_o[24:18];
        got.last = m_axis_tlast_o;
        pool_sb.check_result(got);
      end
      if (hold_req && !hold_done) begin
        hold_done = 1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && rx_gaps && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 3);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else
        m_axis_tready_i <= 1'b1;
    end
  end

  // offer one command and wait for its transfer; called at a rising edge
  task automatic send_cmd(logic [2:0] op, logic [5:0] q, logic [7:0] d, logic [7:0] len);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {7'd0, len, d, q, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pool_sb.note_cmd(op, q, d, len);
    if (op <= OP_POP) items_sent++;
  endtask

  // random granted queue, or -1 when none is granted
  function automatic int pick_granted();
    int ids[$];
    for (int i = 0; i < NQ; i++) if (pool_sb.granted[i]) ids.push_back(i);
    if (ids.size() == 0) return -1;
    return ids[$urandom_range(0, ids.size() - 1)];
  endfunction

  // well-formed block push with random content, sometimes cut short
  task automatic push_block(int q);
    int unsigned len;
    int unsigned cut;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 40);
    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len) : len;
    send_cmd(OP_PUSH_BEGIN, q[5:0], 8'($urandom), len[7:0]);
    if (pool_sb.blk_left == 0) return;
    for (int i = 0; i < cut; i++)
      send_cmd(OP_PUSH_BYTE, 6'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    int q;
    int r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: status codes, empty and stray cases, block over open block
    send_cmd(OP_ALLOC, 6'd0, 8'd0, 8'd0);
    send_cmd(OP_FREE, 6'd63, 8'd0, 8'd0);
    send_cmd(OP_PUSH_BYTE, 6'd0, 8'hff, 8'd0);
    send_cmd(OP_PUSH_BEGIN, 6'd63, 8'd0, 8'd1);
    send_cmd(OP_PUSH_BEGIN, 6'd0, 8'd0, 8'd255);
    send_cmd(OP_PUSH_BEGIN, 6'd0, 8'd0, 8'd0);
    send_cmd(OP_POP, 6'd0, 8'd0, 8'd5);
    send_cmd(OP_PUSH_BEGIN, 6'd0, 8'd0, 8'd3);
    send_cmd(OP_PUSH_BYTE, 6'd63, 8'h00, 8'hff);
    send_cmd(OP_PUSH_BYTE, 6'd0, 8'hff, 8'h00);
    send_cmd(OP_PUSH_BYTE, 6'd0, 8'ha5, 8'd0);
    send_cmd(OP_FREE, 6'd0, 8'd0, 8'd0);
    send_cmd(OP_PUSH_BEGIN, 6'd0, 8'd0, 8'd253);
    send_cmd(OP_POP, 6'd0, 8'd0, 8'd0);
    send_cmd(OP_POP, 6'd0, 8'd0, 8'd255);
    send_cmd(OP_PUSH_BEGIN, 6'd0, 8'd0, 8'd5);
    send_cmd(OP_PUSH_BYTE, 6'd0, 8'h5a, 8'd0);
    send_cmd(OP_PUSH_BEGIN, 6'd0, 8'd0, 8'd1);
    send_cmd(OP_PUSH_BYTE, 6'd0, 8'h3c, 8'd0);
    send_cmd(OP_PUSH_BYTE, 6'd0, 8'h77, 8'd0);
    send_cmd(3'd7, 6'd0, 8'd0, 8'd0);
    send_cmd(3'd5, 6'd0, 8'd0, 8'd0);
    // freeing the queue of an open block closes the block
    send_cmd(OP_PUSH_BEGIN, 6'd0, 8'd0, 8'd4);
    send_cmd(OP_POP, 6'd0, 8'd0, 8'd64);
    send_cmd(OP_FREE, 6'd0, 8'd0, 8'd0);
    send_cmd(OP_PUSH_BYTE, 6'd0, 8'h11, 8'd0);
    send_cmd(OP_POP, 6'd0, 8'd0, 8'd1);

    // random: exhaust the pool, release most of it, then mixed traffic
    tx_gaps = 1;
    rx_gaps = 1;
    repeat (NQ + 1) send_cmd(OP_ALLOC, 6'($urandom), 8'($urandom), 8'($urandom));
    for (int i = 4; i < NQ; i++)
      if ($urandom_range(0, 7) != 0) send_cmd(OP_FREE, 6'(i), 8'($urandom), 8'($urandom));
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent > RANDOM_ITEMS - QUIET_ITEMS) begin
        tx_gaps = 0;
        rx_gaps = 0;
      end else if ($urandom_range(0, 15) == 0) begin
        tx_gaps = !tx_gaps;
        rx_gaps = $urandom_range(0, 1);
      end
      if (items_sent > 250 && !hold_req) hold_req <= 1'b1;
      q = pick_granted();
      r = $urandom_range(0, 99);
      if (q < 0 || (r >= 72 && r < 80))
        send_cmd(OP_ALLOC, 6'($urandom), 8'($urandom), 8'($urandom));
      else if (r < 45) push_block(q);
      else if (r < 72)
        send_cmd(OP_POP, q[5:0], 8'($urandom),
                 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 70)));
      else if (r < 88) begin
        if (pool_sb.level[q] != 0 && $urandom_range(0, 1)) send_cmd(OP_POP, q[5:0], 8'd0, 8'd255);
        send_cmd(OP_FREE, q[5:0], 8'($urandom), 8'($urandom));
      end else
        send_cmd(3'($urandom), 6'($urandom), 8'($urandom), 8'($urandom));
    end
    s_axis_tvalid_i <= 1'b0;

    while (pool_sb.pending_res.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (pool_sb.errors == 0 && pool_sb.pending_res.size() == 0)
      $display("** multi_queue_byte_fifo_pool: PASSED **");
    else
      $display("** multi_queue_byte_fifo_pool: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
hdl/mqbfp_pkg.sv
hdl/mqbfp_ram.sv
hdl/multi_queue_byte_fifo_pool.sv
hdl/mqbfp_checker.sv
verif/testbench.sv
